@@ src/saf_pkg.sv @@
// shared types, constants and coil sequence table for the stepper angle follower
package saf_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int ANGLE_W = 16;
    localparam int SUM_W   = 18;
    localparam int GAIN_W  = 19;
    localparam int PROD_W  = SUM_W + GAIN_W;
    localparam int DEG_W   = 20;
    localparam int D5_W    = 23;
    localparam int Y_W     = 13;
    localparam int RECIP_W = 13;
    localparam int STEP_W  = 10;
    localparam int TICK_W  = 16;
    localparam int PHASE_W = 3;
    localparam int COIL_W  = 4;

    localparam logic signed [SUM_W-1:0]  ANGLE_OFFSET = 18'sd6431;
    localparam logic signed [GAIN_W-1:0] DEG_GAIN     = 19'sd234803;
    localparam logic signed [PROD_W-1:0] ROUND_HALF   = 37'sd32768;
    localparam logic signed [D5_W-1:0]   STEP_BIAS    = 23'sd1152;
    localparam logic [RECIP_W-1:0]       RECIP_NINE   = 13'd7282;
    localparam logic [TICK_W-1:0]        TPP_RESET    = 16'd1000;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_PHASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_DIRECTION  = 1'd1;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_TARGET = 1'b1;

    typedef struct packed {
        logic                   cmd;
        logic signed [D5_W-1:0] d5;
    } t_item;

    typedef struct packed {
        logic [TICK_W-1:0] ticks_per_phase;
        logic              swap_direction;
    } t_cfg;

    typedef struct packed {
        logic [STEP_W-1:0] steps_remaining;
        logic              target_rejected;
        logic              busy_res;
        logic [COIL_W-1:0] coils;
    } t_result;

    function automatic logic [COIL_W-1:0] coil_seq(input logic bwd, input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        pat = 4'h1;
        if (!bwd) begin
            unique case (idx)
                3'd0: pat = 4'h1;
                3'd1: pat = 4'h3;
                3'd2: pat = 4'h2;
                3'd3: pat = 4'h6;
                3'd4: pat = 4'h4;
                3'd5: pat = 4'hC;
                3'd6: pat = 4'h8;
                3'd7: pat = 4'h9;
                default: pat = 4'h1;
            endcase
        end else begin
            unique case (idx)
                3'd0: pat = 4'h1;
                3'd1: pat = 4'h9;
                3'd2: pat = 4'h8;
                3'd3: pat = 4'hC;
                3'd4: pat = 4'h4;
                3'd5: pat = 4'h6;
                3'd6: pat = 4'h2;
                3'd7: pat = 4'h3;
                default: pat = 4'h1;
            endcase
        end
        return pat;
    endfunction

endpackage

@@ src/saf_front.sv @@
// input stage: accepts words and converts target angles to scaled degrees
module saf_front #(
    parameter int QUEUE_DEPTH = saf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_cmd,
    input  logic signed [saf_pkg::ANGLE_W-1:0]   i_angle,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     i_free,
    output logic                                 o_valid,
    output saf_pkg::t_item                       o_item
);
    import saf_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 2) ? CNT_W : 2;

    logic                     r_v1, r_v2, r_v3;
    logic                     r_cmd1, r_cmd2, r_cmd3;
    logic signed [SUM_W-1:0]  r_s1;
    logic signed [PROD_W-1:0] r_p2;
    logic signed [D5_W-1:0]   r_d5;

    logic [1:0]               w_inflight;
    logic                     w_accept;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_round;
    logic signed [DEG_W-1:0]  w_deg;
    logic signed [D5_W-1:0]   w_d5;

    assign w_inflight = {1'b0, r_v1} + {1'b0, r_v2} + {1'b0, r_v3};
    assign o_ready    = CMP_W'(w_inflight) < CMP_W'(i_free);
    assign w_accept   = i_valid && o_ready;

    assign w_prod  = r_s1 * DEG_GAIN;
    assign w_round = r_p2 + ROUND_HALF;
    assign w_deg   = w_round[DEG_W+15:16];
    assign w_d5    = {{(D5_W-DEG_W){w_deg[DEG_W-1]}}, w_deg}
                   + {{(D5_W-DEG_W-2){w_deg[DEG_W-1]}}, w_deg, 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_cmd1 <= i_cmd;
        r_s1   <= {{(SUM_W-ANGLE_W){i_angle[ANGLE_W-1]}}, i_angle} + ANGLE_OFFSET;
        r_cmd2 <= r_cmd1;
        r_p2   <= w_prod;
        r_cmd3 <= r_cmd2;
        r_d5   <= w_d5;
    end

    assign o_valid     = r_v3;
    assign o_item.cmd  = r_cmd3;
    assign o_item.d5   = r_d5;

endmodule

@@ src/saf_queue.sv @@
// short word queue between the input stage and the step sequencer
module saf_queue #(
    parameter int QUEUE_DEPTH = saf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_valid,
    input  saf_pkg::t_item                   i_wr_item,
    input  logic                             i_rd,
    output logic                             o_rd_valid,
    output saf_pkg::t_item                   o_rd_item,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_free
);
    import saf_pkg::*;

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_slot [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [AW-1:0]    n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_rd;

    assign o_rd_valid = r_count != '0;
    assign o_rd_item  = r_slot[r_rd_ptr];
    assign o_free     = CNT_W'(QUEUE_DEPTH) - r_count;
    assign w_rd       = i_rd && o_rd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr_valid) begin
            n_wr_ptr = (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr_valid && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr_valid && w_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_wr_valid) begin
            r_slot[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

@@ src/saf_back.sv @@
// step sequencer: move setup, half-step playback and output register
module saf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  saf_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  saf_pkg::t_item   i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output saf_pkg::t_result o_result
);
    import saf_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_APPLY
    } t_state;

    t_state                  r_state, n_state;
    logic signed [D5_W-1:0]  r_last5, n_last5;
    logic signed [D5_W-1:0]  r_x, n_x;
    logic [STEP_W-1:0]       r_q, n_q;
    logic                    r_neg, n_neg;
    logic [STEP_W-1:0]       r_left, n_left;
    logic [PHASE_W-1:0]      r_phase, n_phase;
    logic [TICK_W-1:0]       r_tick, n_tick;
    logic                    r_bwd, n_bwd;
    logic [COIL_W-1:0]       r_coils, n_coils;
    logic                    r_ov, n_ov;
    t_result                 r_res, n_res;

    logic                    w_out_free;
    logic                    w_emit;
    logic                    w_rej;
    logic [TICK_W-1:0]       w_limit;
    logic [TICK_W-1:0]       w_tc1;
    logic                    w_adv;
    logic [D5_W-1:0]         w_mag;
    logic [Y_W-1:0]          w_y;
    logic [Y_W+RECIP_W-1:0]  w_prod;
    logic [STEP_W-1:0]       w_left_dec;
    logic                    w_dir;

    assign w_out_free = !r_ov || i_ready;
    assign w_limit    = (i_cfg.ticks_per_phase == '0) ? TICK_W'(1) : i_cfg.ticks_per_phase;
    assign w_tc1      = r_tick + 1'b1;
    assign w_adv      = (w_tc1 >= w_limit) || (w_tc1 == '0);
    assign w_mag      = r_x[D5_W-1] ? D5_W'(-r_x) : D5_W'(r_x);
    assign w_y        = w_mag[Y_W+7:8];
    assign w_prod     = w_y * RECIP_NINE;
    assign w_left_dec = r_left - 1'b1;
    assign w_dir      = r_neg ^ i_cfg.swap_direction;

    always_comb begin
        n_state = r_state;
        n_last5 = r_last5;
        n_x     = r_x;
        n_q     = r_q;
        n_neg   = r_neg;
        n_left  = r_left;
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bwd   = r_bwd;
        n_coils = r_coils;
        o_pop   = 1'b0;
        w_emit  = 1'b0;
        w_rej   = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                if (i_valid && w_out_free) begin
                    o_pop = 1'b1;
                    if (i_item.cmd == CMD_TARGET) begin
                        if (r_left != '0) begin
                            w_emit = 1'b1;
                            w_rej  = 1'b1;
                        end else begin
                            n_x     = i_item.d5 - r_last5 + STEP_BIAS;
                            n_last5 = i_item.d5;
                            n_state = ST_DIV;
                        end
                    end else begin
                        w_emit = 1'b1;
                        if (r_left != '0) begin
                            n_tick = w_adv ? '0 : w_tc1;
                            if (w_adv) begin
                                if (r_phase == PHASE_W'(7)) begin
                                    n_phase = '0;
                                    n_left  = w_left_dec;
                                    if (w_left_dec != '0) begin
                                        n_coils = coil_seq(r_bwd, '0);
                                    end
                                end else begin
                                    n_phase = r_phase + 1'b1;
                                    n_coils = coil_seq(r_bwd, r_phase + 1'b1);
                                end
                            end
                        end
                    end
                end
            end
            ST_DIV: begin
                n_q     = w_prod[Y_W+RECIP_W-1:16];
                n_neg   = r_x[D5_W-1];
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = ST_RUN;
                    if (r_q != '0) begin
                        n_left  = r_q;
                        n_bwd   = w_dir;
                        n_phase = '0;
                        n_tick  = '0;
                        n_coils = coil_seq(w_dir, '0);
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
        n_ov  = (r_ov && !i_ready) || w_emit;
        n_res = r_res;
        if (w_emit) begin
            n_res.steps_remaining = n_left;
            n_res.target_rejected = w_rej;
            n_res.busy_res        = n_left != '0;
            n_res.coils           = n_coils;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_last5 <= '0;
            r_left  <= '0;
            r_phase <= '0;
            r_tick  <= '0;
            r_bwd   <= 1'b0;
            r_coils <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last5 <= n_last5;
            r_left  <= n_left;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bwd   <= n_bwd;
            r_coils <= n_coils;
            r_ov    <= n_ov;
        end
        r_x   <= n_x;
        r_q   <= n_q;
        r_neg <= n_neg;
        r_res <= n_res;
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

endmodule

@@ src/stepper_angle_follower_halfstep_unit.sv @@
// top level of the half-step stepper angle follower
// Drives a four-coil unipolar stepper in half steps from joint-angle targets.
// Input stream: tuser is the command (0 = timer tick, 1 = new target), tdata the
// target angle in signed Q3.12 radians. Every input word gives exactly one
// output word: coils, busy flag, target-rejected flag and steps remaining.
// A target that arrives while a move is still playing is dropped and flagged.
// Configuration: i_cfg_wr_en writes register i_cfg_index (0 = ticks per phase,
// 1 = swap direction) with i_cfg_data; write only while the block is idle.
// Angle conversion is registered ahead of the queue. A tick or a rejected target
// is answered from the run state; an accepted target first passes the division
// state (angle step divided by the step size) and then the apply state.
// Throughput: one word per cycle for ticks and rejected targets unless the output
// stalls; an accepted target holds the sequencer while the queue keeps filling.
// Reset: synchronous, active low; coils off, no move pending, queue empty,
// ticks per phase 1000 and no direction swap.
// A stalled receiver holds the output word; words keep entering until the queue
// plus the words still in conversion reach its depth, then s_axis_tready drops.
module stepper_angle_follower_halfstep_unit #(
    parameter int QUEUE_DEPTH = saf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // [15:0] target_angle
    input  logic [0:0]                        s_axis_tuser,  // [0] command
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] coils, [4] busy_res, [5] target_rejected, [15:6] steps_remaining
    output logic [15:0]                       m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [saf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [saf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import saf_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg             r_cfg;
    logic             w_front_valid;
    t_item            w_front_item;
    logic [CNT_W-1:0] w_free;
    logic             w_q_valid;
    t_item            w_q_item;
    logic             w_pop;
    t_result          w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_phase <= TPP_RESET;
            r_cfg.swap_direction  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TICKS_PER_PHASE: r_cfg.ticks_per_phase <= i_cfg_data;
                CFG_SWAP_DIRECTION:  r_cfg.swap_direction  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    saf_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser[0]),
        .i_angle (s_axis_tdata),
        .i_free  (w_free),
        .o_valid (w_front_valid),
        .o_item  (w_front_item)
    );

    saf_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_valid),
        .i_wr_item  (w_front_item),
        .i_rd       (w_pop),
        .o_rd_valid (w_q_valid),
        .o_rd_item  (w_q_item),
        .o_free     (w_free)
    );

    saf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_q_valid),
        .i_item   (w_q_item),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = w_result;

endmodule
